// File: hw/rtl/ebcs_pkg.sv
// Shared constants and types of the error beep code sequencer.
package ebcs_pkg;

   localparam int unsigned MaskWidth    = 8;
   localparam int unsigned TpsWidth     = 16;
   localparam int unsigned SecondsWidth = 16;
   localparam int unsigned SlotWidth    = 4;
   localparam int unsigned PhaseWidth   = 5;

   localparam logic [TpsWidth-1:0]   TPS_RESET   = 16'd50;
   localparam logic [SlotWidth-1:0]  TONE_SLOT   = 4'd8;
   localparam logic [SlotWidth-1:0]  SCAN_SLOTS  = 4'd9;
   localparam logic [PhaseWidth-1:0] TONE_PHASES = 5'd8;
   localparam int unsigned           PhaseShift  = 3;

   // One timer tick as seen by the beep sequencer.
   typedef struct packed {
      logic                 step;
      logic [MaskWidth-1:0] mask;
      logic [TpsWidth-1:0]  tps;
   } ebcs_tick_type;

endpackage

// File: hw/rtl/ebcs_beep_seq.sv
// Beep sequencer: scans the error bits and drives the buzzer level.
module ebcs_beep_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  ebcs_pkg::ebcs_tick_type tick,
   output logic                  buzzer_level
);
   import ebcs_pkg::*;

   logic [SlotWidth-1:0]  bit_position_ff, bit_position_in;
   logic [PhaseWidth-1:0] phases_left_ff, phases_left_in;
   logic [TpsWidth-1:0]   phase_ticks_ff, phase_ticks_in;
   logic                  buzzer_ff, buzzer_in;
   logic [SlotWidth-1:0]  bit_inc;

   assign bit_inc = bit_position_ff + 1'b1;

   always_comb begin
      bit_position_in = bit_position_ff;
      phases_left_in  = phases_left_ff;
      phase_ticks_in  = phase_ticks_ff;
      buzzer_in       = buzzer_ff;
      if (phase_ticks_ff == '0) begin
         if (phases_left_ff == '0) begin
            if (bit_position_ff == TONE_SLOT) begin
               phases_left_in = TONE_PHASES;
               phase_ticks_in = tick.tps;
            end else if (bit_position_ff < TONE_SLOT &&
                         tick.mask[bit_position_ff[2:0]]) begin
               // A set bit k gives 2*(k+1) alternating phases.
               phases_left_in = {bit_inc, 1'b0};
               phase_ticks_in = tick.tps;
            end
            bit_position_in = (bit_inc >= SCAN_SLOTS) ? '0 : bit_inc;
            buzzer_in       = 1'b0;
         end else begin
            // Slot zero with phases pending is the steady tone.
            if (bit_position_ff != '0) begin
               buzzer_in = ~phases_left_ff[0];
            end else begin
               buzzer_in = 1'b1;
            end
            phase_ticks_in = tick.tps >> PhaseShift;
            phases_left_in = phases_left_ff - 1'b1;
         end
      end else begin
         phase_ticks_in = phase_ticks_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff <= '0;
         phases_left_ff  <= '0;
         phase_ticks_ff  <= '0;
         buzzer_ff       <= 1'b0;
      end else if (tick.step) begin
         bit_position_ff <= bit_position_in;
         phases_left_ff  <= phases_left_in;
         phase_ticks_ff  <= phase_ticks_in;
         buzzer_ff       <= buzzer_in;
      end
   end

   assign buzzer_level = buzzer_ff;

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      bit_position_ff <= TONE_SLOT)
      else $error("bit position left the scan range");

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      phases_left_ff <= 5'd16)
      else $error("phase count above sixteen");

   a_pause_quiet : assert property (@(posedge clock) disable iff (reset)
      tick.step && phase_ticks_ff == '0 && phases_left_ff == '0 |=> !buzzer_ff)
      else $error("buzzer sounds at the start of a pause");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !tick.step |=> $stable(bit_position_ff) && $stable(phases_left_ff)
                     && $stable(buzzer_ff))
      else $error("sequencer moved without a tick");

endmodule

// File: hw/rtl/error_beep_code_sequencer_core.sv
// Top level of the error beep code sequencer: prescaler, seconds and result.
//
// Each item on the req_ channel is one timer tick carrying the 8-bit error
// mask. Each accepted item yields exactly one item on the rsp_ channel with
// the buzzer level and the seconds count after that tick.
// The tick updates all counters in the cycle it is accepted; those counters
// are also the result register, so the result is valid in the cycle after the
// item is taken. One item per cycle is sustained while results are taken:
// req_tready is high whenever the result slot is empty or its item is being
// taken in the same cycle, so only the single result slot sets the throughput.
// When the receiver stalls, the result holds and req_tready drops after one
// result is waiting; no item is lost or repeated.
// ticks_per_second is written through csr_we/csr_wdata and takes effect
// from the next tick. Reset (synchronous, active high) clears all counters,
// silences the buzzer, empties the result slot and sets ticks_per_second to
// 50. No clearing pass is needed after reset.
module error_beep_code_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] error_mask
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] buzzer_on, [16:1] seconds, [23:17] zero
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // ticks_per_second
);
   import ebcs_pkg::*;

   logic [TpsWidth-1:0]     tps_ff;
   logic [TpsWidth-1:0]     prescale_ff, prescale_in, prescale_inc;
   logic [SecondsWidth-1:0] seconds_ff, seconds_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept;
   logic                    buzzer_level;
   ebcs_tick_type           tick;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign prescale_inc = prescale_ff + 1'b1;

   always_comb begin
      prescale_in = prescale_inc;
      seconds_in  = seconds_ff;
      if (prescale_inc >= tps_ff) begin
         prescale_in = '0;
         seconds_in  = seconds_ff + 1'b1;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_we) begin
         tps_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= '0;
         seconds_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prescale_ff <= prescale_in;
            seconds_ff  <= seconds_in;
         end
      end
   end

   assign tick.step = accept;
   assign tick.mask = req_tdata;
   assign tick.tps  = tps_ff;

   ebcs_beep_seq u_beep_seq (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .buzzer_level (buzzer_level)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, seconds_ff, buzzer_level};

   a_seconds_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(seconds_ff) && $stable(prescale_ff))
      else $error("seconds moved without an accepted item");

   a_seconds_step : assert property (@(posedge clock) disable iff (reset)
      accept |=> seconds_ff == $past(seconds_ff) ||
                 seconds_ff == $past(seconds_ff) + 16'd1)
      else $error("seconds advanced by more than one");

   a_result_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !accept)
      else $error("item accepted over a stalled result");

endmodule
